/* rtl/binary_to_decimal_ascii_emitter_defines.svh */
// Assertion macros shared by the checker files.
`ifndef BINARY_TO_DECIMAL_ASCII_EMITTER_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_EMITTER_DEFINES_SVH

// Checks that a condition implies an expression in the same cycle.
`define B2DA_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed");

// Checks that a condition implies an expression in the following cycle.
`define B2DA_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

/* rtl/b2da_pkg.sv */
`default_nettype none

package b2da_pkg;

   // Field widths and sizes.
   localparam int ValueWidth = 16;
   localparam int CharWidth  = 6;
   localparam int BcdWidth   = 4;
   localparam int NumDigits  = 5;

   // ASCII code of the character zero.
   localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

   // Sequencer states.
   typedef enum logic [1:0] {
      StIdle,
      StConvert,
      StLead,
      StEmit
   } state_type;

   // Controls broadcast from the sequencer to every digit cell.
   typedef struct packed {
      logic clear;
      logic shift;
      logic emit;
   } ctrl_type;

endpackage

`default_nettype wire

/* rtl/b2da_req_if.sv */
`default_nettype none

interface b2da_req_if;
   logic                              valid;
   logic                              ready;
   logic [b2da_pkg::ValueWidth-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* rtl/b2da_rsp_if.sv */
`default_nettype none

interface b2da_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [b2da_pkg::CharWidth-1:0]    digit_char;
   logic                              last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

/* rtl/b2da_cell.sv */
`default_nettype none

// One BCD digit of the conversion chain. While converting it performs the
// add-3 adjust and shifts in a bit from its lower neighbor; while emitting
// it takes over the digit of its lower neighbor.
module b2da_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  b2da_pkg::ctrl_type         ctrl,
   input  wire                              bit_in,
   input  wire  [b2da_pkg::BcdWidth-1:0]    digit_in,
   output logic                             bit_out,
   output logic [b2da_pkg::BcdWidth-1:0]    digit
);
   import b2da_pkg::*;

   logic [BcdWidth-1:0] digit_ff;
   logic [BcdWidth-1:0] digit_in_next;
   logic [BcdWidth-1:0] adjusted;

   // Add three to digits of five or more before the shift.
   always_comb begin
      if (digit_ff >= BcdWidth'(5)) begin
         adjusted = digit_ff + BcdWidth'(3);
      end else begin
         adjusted = digit_ff;
      end
   end

   assign bit_out = adjusted[BcdWidth-1];
   assign digit   = digit_ff;

   // Select the next digit value.
   always_comb begin
      priority if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.shift) begin
         digit_in_next = {adjusted[BcdWidth-2:0], bit_in};
      end else if (ctrl.emit) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in_next;
      end
   end

endmodule

`default_nettype wire

/* rtl/binary_to_decimal_ascii_emitter.sv */
// Prints an unsigned 16-bit number as ASCII decimal digits.
// The req channel carries one number per transaction. The rsp channel
// returns one character per transaction, most significant digit first,
// with no leading zeros, and last set on the final digit; zero prints as
// a single '0'.
// A row of five BCD digit cells converts the number by shift-and-add-3,
// one bit per cycle, then skips leading zero digits at one per cycle and
// shifts the digits out through an output register.
// The block takes no new number until it has loaded the last character
// of the previous one; req ready is high only while the block is idle;
// the next number can be accepted while the final character still waits
// in the output register.
// When the receiver stalls, the output register holds its character and
// the digit chain waits. Synchronous reset empties the output register
// and returns the block to idle.
`default_nettype none

module binary_to_decimal_ascii_emitter (
   input  wire         clock,
   input  wire         reset,
   b2da_req_if.sink    req_chan,
   b2da_rsp_if.source  rsp_chan
);
   import b2da_pkg::*;

   localparam int CountWidth  = $clog2(ValueWidth);
   localparam int RemainWidth = $clog2(NumDigits + 1);

   state_type                 state_ff;
   state_type                 state_in;
   logic [ValueWidth-1:0]     value_ff;
   logic [ValueWidth-1:0]     value_in;
   logic [CountWidth-1:0]     count_ff;
   logic [CountWidth-1:0]     count_in;
   logic [RemainWidth-1:0]    remain_ff;
   logic [RemainWidth-1:0]    remain_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [CharWidth-1:0]      rsp_char_ff;
   logic                      rsp_last_ff;

   ctrl_type                  ctrl;
   logic                      accept;
   logic                      out_load;
   logic                      skip;
   logic [NumDigits-1:0]      carry;
   logic [BcdWidth-1:0]       digits [NumDigits];
   logic [BcdWidth-1:0]       top_digit;

   // Digit chain: cell 0 is the least significant digit.
   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      if (i == 0) begin : g_first
         b2da_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .bit_in   (value_ff[ValueWidth-1]),
            .digit_in ('0),
            .bit_out  (carry[i]),
            .digit    (digits[i])
         );
      end else begin : g_rest
         b2da_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .bit_in   (carry[i-1]),
            .digit_in (digits[i-1]),
            .bit_out  (carry[i]),
            .digit    (digits[i])
         );
      end
   end

   assign top_digit = digits[NumDigits-1];
   assign accept    = req_chan.valid && req_chan.ready;
   assign skip      = (top_digit == '0) && (remain_ff > RemainWidth'(1));

   // Sequencer outputs.
   always_comb begin
      req_chan.ready = (state_ff == StIdle);
      out_load       = (state_ff == StEmit) && (!rsp_valid_ff || rsp_chan.ready);
      ctrl.clear     = accept;
      ctrl.shift     = (state_ff == StConvert);
      ctrl.emit      = ((state_ff == StLead) && skip) || out_load;
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StConvert;
            end
         end
         StConvert: begin
            if (count_ff == CountWidth'(ValueWidth - 1)) begin
               state_in = StLead;
            end
         end
         StLead: begin
            if (!skip) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (out_load && (remain_ff == RemainWidth'(1))) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Binary shift register, bit counter and digit counter.
   always_comb begin
      value_in  = value_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      if (accept) begin
         value_in  = req_chan.value;
         count_in  = '0;
         remain_in = RemainWidth'(NumDigits);
      end else if (ctrl.shift) begin
         value_in = {value_ff[ValueWidth-2:0], 1'b0};
         count_in = count_ff + CountWidth'(1);
      end else if (ctrl.emit) begin
         remain_in = remain_ff - RemainWidth'(1);
      end
   end

   // Output register valid flag.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (out_load) begin
         rsp_char_ff <= AsciiZero + CharWidth'(top_digit);
         rsp_last_ff <= (remain_ff == RemainWidth'(1));
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.digit_char = rsp_char_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/b2da_checker.sv */
`default_nettype none

`include "binary_to_decimal_ascii_emitter_defines.svh"

// Port-level checks of the emitter.
module b2da_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_ready,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire [b2da_pkg::CharWidth-1:0]   digit_char,
   input wire                             last
);
   import b2da_pkg::*;

   // A stalled character holds.
   `B2DA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(digit_char) && $stable(last))

   // Every character is a decimal digit.
   `B2DA_ASSERT_NOW(a_rsp_digit, rsp_valid, (digit_char >= 6'd48) && (digit_char <= 6'd57))

   // The block is busy for the conversion after taking a number.
   `B2DA_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready)

   // Digits of one number follow each other without a gap.
   `B2DA_ASSERT_NEXT(a_no_gap, rsp_valid && rsp_ready && !last, rsp_valid)

endmodule

bind binary_to_decimal_ascii_emitter b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .digit_char (rsp_chan.digit_char),
   .last       (rsp_chan.last)
);

`default_nettype wire
